// File: rtl/core/sobel_pkg.sv
// Shared constants and types for the Sobel edge glow core.
package sobel_pkg;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 11;
   localparam int CFG_W   = 12;

   // widest supported row; sets line buffer depth and width clamp
   localparam int MAX_WIDTH = 2048;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_FULL_RANGE   = 3'd2;
   localparam logic [2:0] REG_BLEND_WEIGHT = 3'd3;
   localparam logic [2:0] REG_EDGE_GAIN    = 3'd4;

   localparam logic [7:0] VIDEO_LO = 8'd16;
   localparam logic [7:0] VIDEO_HI = 8'd235;

   // one result slot
   typedef struct packed {
      logic [7:0]  value;
      logic [10:0] row;
      logic [10:0] column;
      logic        frame_done;
   } result_type;

   // job handed from the window stage to the edge unit
   typedef struct packed {
      logic [7:0] tl, tm, tr, ml, mm, mr, bl, bm, br;
   } window_type;

endpackage

// File: rtl/core/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sobel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/sobel_edge.sv
// Sobel gradient, iterative square root, gain and blend for one window.
module sobel_edge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sobel_pkg::window_type   win,
   input  logic                    full_range,
   input  logic [8:0]              blend_weight,
   input  logic [9:0]              edge_gain,
   output logic                    done,
   output logic [7:0]              result
);
   typedef enum logic [2:0] {S_IDLE, S_GRAD, S_SQ, S_ROOT, S_GAIN, S_BLEND, S_OUT} state_type;

   state_type   state_ff;
   logic signed [11:0] gx_ff, gy_ff;
   logic [21:0] v_ff;
   logic [21:0] res_ff;
   logic [21:0] bit_ff;
   logic [19:0] s_ff;
   logic [7:0]  mm_ff;
   logic [7:0]  out_ff;
   logic        done_ff;

   logic signed [11:0] gx_in, gy_in;
   logic [21:0] sum_rb;
   logic [7:0]  lo, hi;
   logic [10:0] mag3;
   logic [20:0] scaled;
   logic [9:0]  sat;
   logic [7:0]  clamped;
   logic [8:0]  w;
   logic [17:0] mix;
   logic [9:0]  mixs;

   always_comb begin
      gx_in = (12'(win.tr) + {3'd0, win.mr, 1'b0} + 12'(win.br))
            - (12'(win.tl) + {3'd0, win.ml, 1'b0} + 12'(win.bl));
      gy_in = (12'(win.bl) + {3'd0, win.bm, 1'b0} + 12'(win.br))
            - (12'(win.tl) + {3'd0, win.tm, 1'b0} + 12'(win.tr));
      sum_rb = res_ff + bit_ff;
      lo = full_range ? 8'd0 : sobel_pkg::VIDEO_LO;
      hi = full_range ? 8'd255 : sobel_pkg::VIDEO_HI;
      mag3 = 11'((12'(res_ff) * 12'd3) >> 1);
      scaled = 21'((32'(mag3) * 32'(edge_gain)) >> 8);
      sat = (scaled > 21'd1000) ? 10'd1000 : scaled[9:0];
      if (sat < 10'(lo)) clamped = lo;
      else if (sat > 10'(hi)) clamped = hi;
      else clamped = sat[7:0];
      w = (blend_weight > 9'd256) ? 9'd256 : blend_weight;
      mix = 18'(((9'd256 - w) * s_ff[7:0]) + (w * mm_ff));
      mixs = 10'(mix >> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               gx_ff <= gx_in;
               gy_ff <= gy_in;
               mm_ff <= win.mm;
               state_ff <= S_GRAD;
            end
            S_GRAD: begin
               // one product per cycle
               v_ff <= 22'(gx_ff * gx_ff);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               v_ff <= v_ff + 22'(gy_ff * gy_ff);
               res_ff <= '0;
               bit_ff <= 22'h100000;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               // one result bit per cycle; leading-bit skip not needed
               if (v_ff >= sum_rb) begin
                  v_ff   <= v_ff - sum_rb;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == 22'd1) state_ff <= S_GAIN;
            end
            S_GAIN: begin
               s_ff <= 20'(clamped);
               state_ff <= S_BLEND;
            end
            S_BLEND: begin
               if (mixs < 10'(lo)) out_ff <= lo;
               else if (mixs > 10'(hi)) out_ff <= hi;
               else out_ff <= mixs[7:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = out_ff;
endmodule

// File: rtl/core/sobel_edge_glow_blend_core.sv
// Sobel edge glow core: streaming 3x3 Sobel magnitude blended back into the
// luma plane. Pixels arrive in raster order on req_; results leave on rsp_
// tagged with row and column, since output lags input by one row and one
// column. One pixel is handled at a time. An interior pixel is accepted, both
// line buffers (synchronous RAMs with one write and one read port) are read
// and its results are planned, then the edge unit runs window latch, the
// squaring of gx and gy, the square-root iterations, gain, blend, output and
// handoff, and each result passes through the output register (load,
// transfer), the transfer waiting while rsp_stall is high. A border pixel
// skips the edge unit; up to three results follow one input. Border pixels
// pass through unclamped. Line buffer contents are undefined until a full
// row is written; no clearing pass is run. Configure only while idle.
module sobel_edge_glow_blend_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic [10:0] rsp_row,
   output logic [10:0] rsp_column,
   output logic        rsp_last,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);
   localparam int AW = $clog2(sobel_pkg::MAX_WIDTH);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_PLAN, S_EDGE, S_EMIT} state_type;

   // configuration
   logic [11:0] width_ff, height_ff;
   logic        full_ff;
   logic [8:0]  blend_ff;
   logic [9:0]  gain_ff;

   state_type   state_ff;
   logic [10:0] col_ff, row_ff;
   logic [10:0] c_ff, r_ff;
   logic [7:0]  pix_ff;
   logic [7:0]  t_ff, m_ff;
   logic [47:0] win_ff;
   logic [11:0] w_ff, h_ff;
   sobel_pkg::result_type slot_ff [3];
   logic [1:0]  n_ff, k_ff;
   logic        edge_start_ff;

   logic [7:0]  t_rd, m_rd;
   logic        ram_we;
   logic [11:0] w_eff, h_eff;
   logic [10:0] c_eff, r_eff;
   logic        edge_done;
   logic [7:0]  edge_val;
   sobel_pkg::window_type win;

   assign csr_ready = 1'b1;

   always_comb begin
      // effective size, clamped to supported range
      if (width_ff < 12'd3) w_eff = 12'd3;
      else if (width_ff > 12'(sobel_pkg::MAX_WIDTH)) w_eff = 12'(sobel_pkg::MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff < 12'd3) h_eff = 12'd3;
      else if (height_ff > 12'd2048) h_eff = 12'd2048;
      else h_eff = height_ff;
      c_eff = (12'(col_ff) >= w_eff) ? 11'd0 : col_ff;
      r_eff = (12'(row_ff) >= h_eff) ? 11'd0 : row_ff;
   end

   assign ram_we = (state_ff == S_PLAN);

   sobel_ram #(.WIDTH(8), .DEPTH(sobel_pkg::MAX_WIDTH)) u_prev2 (
      .clock(clock), .wr_en(ram_we), .wr_addr(c_ff[AW-1:0]), .wr_data(m_rd),
      .rd_addr(c_eff[AW-1:0]), .rd_data(t_rd));
   sobel_ram #(.WIDTH(8), .DEPTH(sobel_pkg::MAX_WIDTH)) u_prev (
      .clock(clock), .wr_en(ram_we), .wr_addr(c_ff[AW-1:0]), .wr_data(pix_ff),
      .rd_addr(c_eff[AW-1:0]), .rd_data(m_rd));

   // window: bits 0..23 column C-1 (t,m,b), 24..47 column C-2
   always_comb begin
      win.tl = win_ff[31:24]; win.ml = win_ff[39:32]; win.bl = win_ff[47:40];
      win.tm = win_ff[7:0];   win.mm = win_ff[15:8];  win.bm = win_ff[23:16];
      win.tr = t_rd;          win.mr = m_rd;          win.br = pix_ff;
   end

   sobel_edge u_edge (
      .clock(clock), .reset(reset), .start(edge_start_ff), .win(win),
      .full_range(full_ff), .blend_weight(blend_ff), .edge_gain(gain_ff),
      .done(edge_done), .result(edge_val));

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
         full_ff   <= 1'b1;
         blend_ff  <= 9'd192;
         gain_ff   <= 10'd384;
         state_ff  <= S_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         win_ff    <= '0;
         rsp_valid <= 1'b0;
         edge_start_ff <= 1'b0;
      end else begin
         edge_start_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               sobel_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_data;
               sobel_pkg::REG_FRAME_HEIGHT: height_ff <= csr_data;
               sobel_pkg::REG_FULL_RANGE:   full_ff   <= csr_data[0];
               sobel_pkg::REG_BLEND_WEIGHT: blend_ff  <= csr_data[8:0];
               sobel_pkg::REG_EDGE_GAIN:    gain_ff   <= csr_data[9:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               // RAM read issued at c_eff this cycle
               c_ff   <= c_eff;
               r_ff   <= r_eff;
               w_ff   <= w_eff;
               h_ff   <= h_eff;
               pix_ff <= req_pixel;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_PLAN;
            S_PLAN: begin
               logic [1:0] n;
               logic       is_lastc;
               n = 2'd0;
               is_lastc = (12'(c_ff) == w_ff - 12'd1);
               // read data moves on once the column advances; hold it
               t_ff <= t_rd;
               m_ff <= m_rd;
               if (r_ff == 11'd0) begin
                  slot_ff[0] <= '{pix_ff, 11'd0, c_ff, 1'b0};
                  n = 2'd1;
               end else if (r_ff >= 11'd2) begin
                  if (c_ff >= 11'd1) begin
                     slot_ff[0] <= '{win_ff[15:8], r_ff - 11'd1, c_ff - 11'd1, 1'b0};
                     n = 2'd1;
                  end
                  if (is_lastc) begin
                     slot_ff[n] <= '{m_rd, r_ff - 11'd1, c_ff, 1'b0};
                     n = n + 2'd1;
                  end
                  if (12'(r_ff) == h_ff - 12'd1) begin
                     slot_ff[n] <= '{pix_ff, r_ff, c_ff, is_lastc};
                     n = n + 2'd1;
                  end
               end
               n_ff <= n;
               k_ff <= '0;
               // advance counters
               if (12'(c_ff) + 12'd1 >= w_ff) begin
                  col_ff <= '0;
                  row_ff <= (12'(r_ff) + 12'd1 >= h_ff) ? 11'd0 : r_ff + 11'd1;
               end else begin
                  col_ff <= c_ff + 11'd1;
               end
               if (r_ff >= 11'd2 && c_ff >= 11'd2) begin
                  edge_start_ff <= 1'b1;
                  state_ff <= S_EDGE;
               end else begin
                  win_ff <= {win_ff[23:0], pix_ff, m_rd, t_rd};
                  state_ff <= (n == 2'd0) ? S_IDLE : S_EMIT;
               end
            end
            S_EDGE: if (edge_done) begin
               slot_ff[0].value <= edge_val;
               win_ff <= {win_ff[23:0], pix_ff, m_ff, t_ff};
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid) begin
                  rsp_valid      <= 1'b1;
                  rsp_value      <= slot_ff[k_ff].value;
                  rsp_row        <= slot_ff[k_ff].row;
                  rsp_column     <= slot_ff[k_ff].column;
                  rsp_frame_done <= slot_ff[k_ff].frame_done;
                  rsp_last       <= (k_ff + 2'd1 == n_ff);
               end else if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  if (k_ff + 2'd1 == n_ff) state_ff <= S_IDLE;
                  else k_ff <= k_ff + 2'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: test/testbench.sv
// Self-checking testbench for the Sobel edge glow core.
`timescale 1ns / 1ps

module testbench;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // DUT ports; all inputs driven to known values from time zero
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_value;
   logic [10:0] rsp_row;
   logic [10:0] rsp_column;
   logic        rsp_last;
   logic        rsp_frame_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = sobel_pkg::REG_FRAME_WIDTH;
   logic [11:0] csr_data = '0;

   sobel_edge_glow_blend_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_row        (rsp_row),
      .rsp_column     (rsp_column),
      .rsp_last       (rsp_last),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // One expected output pixel
   typedef struct {
      logic [7:0]  value;
      logic [10:0] row;
      logic [10:0] column;
      logic        last;
      logic        frame_done;
   } out_pixel_type;

   out_pixel_type pending_pixels[$];
   int            error_count = 0;

   // Idle percentages for each side; changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // ---------------------------------------------------------------
   // Predictor state: its own copy of config, line stores and window
   // ---------------------------------------------------------------
   logic [11:0] cfg_width;
   logic [11:0] cfg_height;
   logic        cfg_full;
   logic [8:0]  cfg_blend;
   logic [9:0]  cfg_gain;
   logic [7:0]  line_above[2048];   // row r-1
   logic [7:0]  line_above2[2048];  // row r-2
   logic [47:0] win_cols;           // [23:0] column c-1, [47:24] column c-2
   int          cur_col;
   int          cur_row;

   function automatic int root_floor(int v);
      int res;
      int b;
      res = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic int win_px(int col, int r);
      return int'((win_cols >> ((1 - col) * 24 + r * 8)) & 48'hFF);
   endfunction

   function automatic int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Sobel magnitude, gain and blend for the window center
   function automatic int glow_value(int tr, int mr, int br);
      int tl, ml, bl, tm, mm, bm;
      int gx, gy, lo, hi, mag, w, s;
      tl = win_px(0, 0); ml = win_px(0, 1); bl = win_px(0, 2);
      tm = win_px(1, 0); mm = win_px(1, 1); bm = win_px(1, 2);
      gx  = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
      gy  = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
      lo  = cfg_full ? 0 : int'(sobel_pkg::VIDEO_LO);
      hi  = cfg_full ? 255 : int'(sobel_pkg::VIDEO_HI);
      mag = root_floor(gx * gx + gy * gy);
      w   = (cfg_blend > 256) ? 256 : int'(cfg_blend);
      s   = ((3 * mag / 2) * int'(cfg_gain)) >>> 8;
      s   = clip((s > 1000) ? 1000 : s, lo, hi);
      s   = ((256 - w) * s + w * mm) >>> 8;
      return clip(s, lo, hi);
   endfunction

   task automatic predictor_reset();
      cfg_width  = 12'd640;
      cfg_height = 12'd480;
      cfg_full   = 1'b1;
      cfg_blend  = 9'd192;
      cfg_gain   = 10'd384;
      win_cols   = '0;
      cur_col    = 0;
      cur_row    = 0;
   endtask

   task automatic queue_pixel(int v, int r, int c, bit done);
      out_pixel_type e;
      e.value      = v[7:0];
      e.row        = r[10:0];
      e.column     = c[10:0];
      e.last       = 1'b0;
      e.frame_done = done;
      pending_pixels.push_back(e);
   endtask

   // Works out the output pixels caused by one accepted input pixel
   task automatic predict_pixel(logic [7:0] b);
      int w, h, r, c, n;
      logic [7:0] t, m;
      w = (cfg_width < 3) ? 3 : (cfg_width > 2048) ? 2048 : int'(cfg_width);
      h = (cfg_height < 3) ? 3 : (cfg_height > 2048) ? 2048 : int'(cfg_height);
      if (cur_col >= w) cur_col = 0;
      if (cur_row >= h) cur_row = 0;
      r = cur_row;
      c = cur_col;
      t = line_above2[c];
      m = line_above[c];
      n = 0;
      if (r == 0) begin
         queue_pixel(b, 0, c, 1'b0);
         n++;
      end else if (r >= 2) begin
         if (c >= 1) begin
            queue_pixel((c == 1) ? win_px(1, 1) : glow_value(t, m, b), r - 1, c - 1, 1'b0);
            n++;
         end
         if (c == w - 1) begin
            queue_pixel(m, r - 1, c, 1'b0);
            n++;
         end
         if (r == h - 1) begin
            queue_pixel(b, r, c, c == w - 1);
            n++;
         end
      end
      if (n > 0) pending_pixels[$].last = 1'b1;
      win_cols = {win_cols[23:0], b, m, t};
      line_above2[c] = m;
      line_above[c]  = b;
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endtask

   // ---------------------------------------------------------------
   // Driving: all inputs change by NBA at the rising edge; handshakes
   // are judged at the falling edge, where valid and stall are stable.
   // ---------------------------------------------------------------
   task automatic send_pixel(logic [7:0] p);
      bit done;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do begin
         @(negedge clock);
         done = !req_stall;
         @(posedge clock);
      end while (!done);
      predict_pixel(p);
   endtask

   task automatic end_of_stream();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits out all expected output pixels, then the block's latency
   task automatic drain();
      end_of_stream();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] data);
      bit done;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end while (!done);
      csr_valid <= 1'b0;
      case (idx)
         sobel_pkg::REG_FRAME_WIDTH:  cfg_width  = data;
         sobel_pkg::REG_FRAME_HEIGHT: cfg_height = data;
         sobel_pkg::REG_FULL_RANGE:   cfg_full   = data[0];
         sobel_pkg::REG_BLEND_WEIGHT: cfg_blend  = data[8:0];
         sobel_pkg::REG_EDGE_GAIN:    cfg_gain   = data[9:0];
         default: ;
      endcase
   endtask

   task automatic set_size(int w, int h);
      write_reg(sobel_pkg::REG_FRAME_WIDTH, w[11:0]);
      write_reg(sobel_pkg::REG_FRAME_HEIGHT, h[11:0]);
   endtask

   task automatic set_blend(bit full, int weight, int gain);
      write_reg(sobel_pkg::REG_FULL_RANGE, {11'd0, full});
      write_reg(sobel_pkg::REG_BLEND_WEIGHT, weight[11:0]);
      write_reg(sobel_pkg::REG_EDGE_GAIN, gain[11:0]);
   endtask

   // Pixel styles: 0 uniform random, 1 black/white only (strong edges),
   // 2 gentle ramp with noise
   function automatic logic [7:0] make_pixel(int style, int idx);
      case (style)
         1:       return $urandom_range(1) ? 8'hFF : 8'h00;
         2:       return 8'((idx * 7) + $urandom_range(0, 5));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_frame(int w, int h, int style);
      for (int i = 0; i < w * h; i++) send_pixel(make_pixel(style, i));
   endtask

   // ---------------------------------------------------------------
   // Result side: random stall, and a check on every transfer
   // ---------------------------------------------------------------
   task automatic report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      out_pixel_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report("unexpected transfer, row", rsp_row, -1);
         end else begin
            e = pending_pixels.pop_front();
            if (rsp_value !== e.value) report("value", rsp_value, e.value);
            if (rsp_row !== e.row) report("row", rsp_row, e.row);
            if (rsp_column !== e.column) report("column", rsp_column, e.column);
            if (rsp_last !== e.last) report("last", rsp_last, e.last);
            if (rsp_frame_done !== e.frame_done)
               report("frame_done", rsp_frame_done, e.frame_done);
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Power-on blend settings, only the frame size changed
   task automatic test_default_blend();
      set_size(5, 4);
      send_frame(5, 4, 0);
      drain();
   endtask

   // Extremes of gain, weight and range on strong edges
   task automatic test_extremes();
      set_size(3, 3);
      set_blend(1'b0, 0, 1023);          // pure edge, video range clamp
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
      send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF);
      send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
      drain();
      set_blend(1'b1, 256, 0);           // original pixel only
      send_frame(3, 3, 1);
      drain();
      set_blend(1'b1, 511, 1023);        // weight above 256 acts as 256
      send_frame(3, 3, 0);
      drain();
      set_blend(1'b0, 0, 0);             // zero edge, clamped up to 16
      send_frame(3, 3, 0);
      drain();
   endtask

   // Size shrunk mid-frame: column and row counters wrap to zero
   task automatic test_resize_midframe();
      set_blend(1'b1, 128, 300);
      set_size(8, 6);
      for (int i = 0; i < 4 * 8 + 6; i++) send_pixel(make_pixel(0, i));
      drain();
      set_size(5, 3);
      send_frame(5, 3, 0);
      drain();
   endtask

   // Random frames of small size with random blend settings
   task automatic test_random_frames(int pixel_budget);
      int sent, w, h;
      sent = 0;
      while (sent < pixel_budget) begin
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 7);
         set_size(w, h);
         set_blend($urandom_range(1), $urandom_range(0, 300), $urandom_range(0, 1023));
         send_frame(w, h, $urandom_range(2));
         drain();
         sent += w * h;
      end
   endtask

   // Register values out of range clamp to 3..2048
   task automatic test_size_clamp();
      set_blend(1'b1, 64, 700);
      set_size(0, 1);                    // both clamp to 3
      send_frame(3, 3, 0);
      drain();
      set_size(4095, 3);                 // widest row: columns run past 3
      for (int i = 0; i < 40; i++) send_pixel(make_pixel(0, i));
      drain();
      set_size(3, 4095);                 // tallest frame: rows run past 3
      for (int i = 0; i < 30; i++) send_pixel(make_pixel(2, i));
      drain();
   endtask

   initial begin
      predictor_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 69;
      test_default_blend();
      test_extremes();
      test_resize_midframe();
      test_random_frames(40);

      send_idle_pct = 69;
      recv_idle_pct = 37;
      test_random_frames(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(20);
      test_size_clamp();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
